/* sv/record_hit_scan_macros.svh */
// Assertion macros for the record hit scan block.
// Used by record_hit_scan.sv; expects clk and rst_n in the including scope.
`ifndef RECORD_HIT_SCAN_MACROS_SVH
`define RECORD_HIT_SCAN_MACROS_SVH

// Implication checked on every rising edge, off while reset is asserted.
`define RHS_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Same check with the consequent in the cycle after the antecedent.
`define RHS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* sv/rhs_pkg.sv */
// Package for the record hit scan block: field widths, flag table size and
// configuration register indexes. No dependencies.
package rhs_pkg;

    localparam int FLAG_ENTRIES = 256;
    localparam int FLAG_ADDR_W  = (FLAG_ENTRIES > 1) ? $clog2(FLAG_ENTRIES) : 1;

    localparam int COORD_W      = 16;
    localparam int ID_W         = 8;
    localparam int FLAG_INDEX_W = 8;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [1:0] {
        CFG_SEARCH_MODE = 2'd0,
        CFG_STOP_ID     = 2'd1,
        CFG_CURSOR_X    = 2'd2,
        CFG_CURSOR_Y    = 2'd3
    } cfg_index_t;

    localparam logic ACTION_RECORD     = 1'b0;
    localparam logic ACTION_FLAG_WRITE = 1'b1;

    localparam logic MODE_FLAGS  = 1'b0;
    localparam logic MODE_CURSOR = 1'b1;

endpackage

/* sv/record_hit_scan.sv */
// Record hit scan: a stream of records is tested one per cycle against a flag
// table (mode 0, set flags are consumed) or a cursor point (mode 1, strictly
// inside the box). A record whose id equals stop_id ends the scan and yields
// one result: the id of the last matching record, or stop_id when none
// matched. Flag write transactions update one table entry and yield nothing.
// The block accepts one transaction per cycle while the input is not stalled.
// A result enters the output register when its stop record leaves the work
// stage, where the flag table read registered at acceptance is used. A stop
// record that finds the output register still full waits in the work stage
// and stalls the input until the pending result is taken. Depends on rhs_pkg
// and record_hit_scan_macros.svh.
`include "record_hit_scan_macros.svh"

module record_hit_scan
    import rhs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  cfg_index_t              cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic [COORD_W-1:0]      box_left,
    input  logic [COORD_W-1:0]      box_top,
    input  logic [COORD_W-1:0]      box_right,
    input  logic [COORD_W-1:0]      box_bottom,
    input  logic [ID_W-1:0]         record_id,
    input  logic [FLAG_INDEX_W-1:0] flag_index,
    input  logic                    flag_value,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ID_W-1:0]         result_id
);

    localparam logic [FLAG_INDEX_W:0] INDEX_LIMIT = (FLAG_INDEX_W + 1)'(FLAG_ENTRIES);

    // Configuration registers
    logic                 search_mode_reg;
    logic [ID_W-1:0]      stop_id_reg;
    logic [COORD_W-1:0]   cursor_x_reg;
    logic [COORD_W-1:0]   cursor_y_reg;

    // Work stage holding the accepted transaction
    logic                    s1_valid_reg;
    logic                    s1_action_reg;
    logic [COORD_W-1:0]      s1_left_reg;
    logic [COORD_W-1:0]      s1_top_reg;
    logic [COORD_W-1:0]      s1_right_reg;
    logic [COORD_W-1:0]      s1_bottom_reg;
    logic [ID_W-1:0]         s1_id_reg;
    logic [FLAG_INDEX_W-1:0] s1_index_reg;
    logic                    s1_value_reg;

    // Flag table: data in a memory, per-entry valid bits in flip-flops
    logic                    flag_mem [FLAG_ENTRIES];
    logic [FLAG_ENTRIES-1:0] flag_vld_reg;
    logic                    flag_rd_reg;

    // Scan state and output register
    logic [ID_W-1:0] matched_id_reg;
    logic            have_match_reg;
    logic            out_valid_reg;
    logic [ID_W-1:0] result_id_reg;

    logic                   load;
    logic                   commit;
    logic                   out_free;
    logic                   s1_in_range;
    logic [FLAG_ADDR_W-1:0] s1_addr;
    logic [FLAG_ADDR_W-1:0] in_addr;
    logic                   s1_is_record;
    logic                   s1_is_stop;
    logic                   flag_hit;
    logic                   cursor_hit;
    logic                   hit;
    logic                   wr_en;
    logic                   wr_value;

    assign s1_addr     = s1_index_reg[FLAG_ADDR_W-1:0];
    assign in_addr     = flag_index[FLAG_ADDR_W-1:0];
    assign s1_in_range = {1'b0, s1_index_reg} < INDEX_LIMIT;

    assign s1_is_record = s1_valid_reg && (s1_action_reg == ACTION_RECORD);
    assign s1_is_stop   = s1_is_record && (s1_id_reg == stop_id_reg);

    assign flag_hit   = (s1_index_reg != '0) && s1_in_range
                        && flag_vld_reg[s1_addr] && flag_rd_reg;
    assign cursor_hit = (s1_left_reg < cursor_x_reg) && (cursor_x_reg < s1_right_reg)
                        && (s1_top_reg < cursor_y_reg) && (cursor_y_reg < s1_bottom_reg);
    assign hit        = (search_mode_reg == MODE_CURSOR) ? cursor_hit : flag_hit;

    // Only a stop record needs room in the output register.
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = s1_valid_reg && (!s1_is_stop || out_free);
    assign load     = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || commit;

    // A flag write stores its value in an entry; a mode 0 hit clears the entry it used.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_value = 1'b0;
        if (commit && s1_in_range)
        begin
            if (s1_action_reg == ACTION_FLAG_WRITE)
            begin
                wr_en    = 1'b1;
                wr_value = s1_value_reg;
            end
            else if (!s1_is_stop && (search_mode_reg == MODE_FLAGS) && flag_hit)
            begin
                wr_en    = 1'b1;
                wr_value = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= MODE_FLAGS;
            stop_id_reg     <= '0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEARCH_MODE: search_mode_reg <= cfg_data[0];
                CFG_STOP_ID:     stop_id_reg     <= cfg_data[ID_W-1:0];
                CFG_CURSOR_X:    cursor_x_reg    <= cfg_data[COORD_W-1:0];
                CFG_CURSOR_Y:    cursor_y_reg    <= cfg_data[COORD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_action_reg <= action;
            s1_left_reg   <= box_left;
            s1_top_reg    <= box_top;
            s1_right_reg  <= box_right;
            s1_bottom_reg <= box_bottom;
            s1_id_reg     <= record_id;
            s1_index_reg  <= flag_index;
            s1_value_reg  <= flag_value;
        end
    end

    // The read for the incoming transaction happens at the same edge as the
    // write of the one leaving the stage, so a matching write is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            flag_mem[s1_addr] <= wr_value;
        if (load)
        begin
            if (wr_en && (s1_addr == in_addr))
                flag_rd_reg <= wr_value;
            else
                flag_rd_reg <= flag_mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_vld_reg <= '0;
        else if (wr_en)
            flag_vld_reg[s1_addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_id_reg <= '0;
            have_match_reg <= 1'b0;
        end
        else if (commit && s1_is_record)
        begin
            if (s1_is_stop)
                have_match_reg <= 1'b0;
            else if (hit)
            begin
                matched_id_reg <= s1_id_reg;
                have_match_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit && s1_is_stop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit && s1_is_stop)
            result_id_reg <= have_match_reg ? matched_id_reg : stop_id_reg;
    end

    assign out_valid = out_valid_reg;
    assign result_id = result_id_reg;

    `RHS_ASSERT_IMPL(a_ready_when_empty, !s1_valid_reg, in_ready, "input not ready with empty stage")
    `RHS_ASSERT_NEXT(a_stop_gives_result, commit && s1_is_stop, out_valid_reg, "stop record gave no result")
    `RHS_ASSERT_NEXT(a_stop_clears_match, commit && s1_is_stop, !have_match_reg, "match kept after scan end")

endmodule
